// ===== sv/sph_pkg.sv =====
// Shared types and constants for the sample pair history block.
package sph_pkg;

  localparam int DEPTH_DEF = 64;

  localparam int TEMP_W  = 16;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 2;

  // -300 degrees in units of 1/64 degree.
  localparam logic signed [TEMP_W-1:0] SENTINEL = -16'sd19200;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] outside_temp;
    logic signed [TEMP_W-1:0] inside_temp;
  } pair_t;

endpackage

// ===== sv/sph_ring.sv =====
// Pair ring memory with age-relative read addressing and registered read data.
module sph_ring #(
  parameter int DEPTH = sph_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               write_slot,
  input  sph_pkg::pair_t              wr_pair,
  input  logic                        rd_en,
  input  logic                        full,
  input  logic [sph_pkg::INDEX_W-1:0] read_index,
  output sph_pkg::pair_t              rd_pair
);
  import sph_pkg::*;

  localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  pair_t         mem [DEPTH];
  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;
  logic [AW-1:0] rd_addr;

  // Once the ring is full the oldest pair sits at the write slot; before
  // that it sits at slot zero.
  always_comb begin
    sum = (full ? SW'(write_slot) : '0) + SW'(read_index);
    wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    rd_addr = wrapped[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_slot] <= wr_pair;
    end
    if (rd_en) begin
      rd_pair <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/sample_pair_history_min_max.sv =====
// Top level of the sample pair history with running min and max.
// A result passes through the ring read register, then the output register, before
// it is presented, and it is held there while the receiver stalls.
// Throughput: one request per cycle unless the output stalls; the ring takes at
// most one write or one read per request; each sees the state left by the one before.
// Reset clears count, write slot, min, max and newest pair to the sentinel;
// the ring memory is not cleared, as no entry is read before it is written.
module sample_pair_history_min_max #(
  parameter int DEPTH = sph_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // inside_temp[15:0], outside_temp[31:16], read_index[37:32], zero[39:38]
  input  logic [39:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // reading_count[6:0], min_temp[22:7], max_temp[38:23], latest_inside[54:39],
  // latest_outside[70:55], read_inside[86:71], read_outside[102:87], zero[103]
  output logic [103:0]  m_axis_tdata,
  // read_hit[0]
  output logic [0:0]    m_axis_tuser
);
  import sph_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  // Request fields
  kind_t                      kind;
  logic signed [TEMP_W-1:0]   in_a;
  logic signed [TEMP_W-1:0]   in_b;
  logic [INDEX_W-1:0]         read_index;
  logic signed [TEMP_W-1:0]   sat_a;
  logic signed [TEMP_W-1:0]   sat_b;
  logic signed [TEMP_W-1:0]   lo;
  logic signed [TEMP_W-1:0]   hi;

  // Architectural state
  logic [CW-1:0]              held_count, held_count_next;
  logic [AW-1:0]              write_slot, write_slot_next;
  logic signed [TEMP_W-1:0]   run_min, run_min_next;
  logic signed [TEMP_W-1:0]   run_max, run_max_next;
  logic signed [TEMP_W-1:0]   newest_in, newest_in_next;
  logic signed [TEMP_W-1:0]   newest_out, newest_out_next;
  logic                       hit_next;

  // Pipeline
  logic                       accept;
  logic                       advance;
  logic                       s1_valid;
  logic                       s1_hit;
  logic [COUNT_W-1:0]         s1_count;
  logic signed [TEMP_W-1:0]   s1_min;
  logic signed [TEMP_W-1:0]   s1_max;
  logic signed [TEMP_W-1:0]   s1_latest_in;
  logic signed [TEMP_W-1:0]   s1_latest_out;
  pair_t                      rd_pair;
  pair_t                      wr_pair;
  logic                       full;
  logic                       out_valid;
  logic [103:0]               out_data;
  logic                       out_hit;

  assign kind       = kind_t'(s_axis_tuser);
  assign in_a       = s_axis_tdata[15:0];
  assign in_b       = s_axis_tdata[31:16];
  assign read_index = s_axis_tdata[37:32];

  assign sat_a = (in_a < SENTINEL) ? SENTINEL : in_a;
  assign sat_b = (in_b < SENTINEL) ? SENTINEL : in_b;
  assign lo    = (sat_a < sat_b) ? sat_a : sat_b;
  assign hi    = (sat_a < sat_b) ? sat_b : sat_a;
  assign full  = (held_count == CW'(DEPTH));

  assign wr_pair.inside_temp  = sat_a;
  assign wr_pair.outside_temp = sat_b;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    held_count_next = held_count;
    write_slot_next = write_slot;
    run_min_next    = run_min;
    run_max_next    = run_max;
    newest_in_next  = newest_in;
    newest_out_next = newest_out;
    hit_next        = 1'b0;
    case (kind)
      KIND_ADD: begin
        write_slot_next = (write_slot == AW'(DEPTH - 1)) ? '0 : write_slot + 1'b1;
        if (!full) begin
          held_count_next = held_count + 1'b1;
        end
        newest_in_next  = sat_a;
        newest_out_next = sat_b;
        if (held_count == '0) begin
          run_min_next = lo;
          run_max_next = hi;
        end else begin
          if (lo < run_min) run_min_next = lo;
          if (hi > run_max) run_max_next = hi;
        end
      end
      KIND_READ: begin
        hit_next = (CMPW'(read_index) < CMPW'(held_count));
      end
      KIND_CLEAR: begin
        held_count_next = '0;
        write_slot_next = '0;
        run_min_next    = SENTINEL;
        run_max_next    = SENTINEL;
        newest_in_next  = SENTINEL;
        newest_out_next = SENTINEL;
      end
      default: begin
      end
    endcase
  end

  sph_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk        (clk),
    .wr_en      (accept && (kind == KIND_ADD)),
    .write_slot (write_slot),
    .wr_pair    (wr_pair),
    .rd_en      (accept && (kind == KIND_READ)),
    .full       (full),
    .read_index (read_index),
    .rd_pair    (rd_pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      write_slot <= '0;
      run_min    <= SENTINEL;
      run_max    <= SENTINEL;
      newest_in  <= SENTINEL;
      newest_out <= SENTINEL;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        write_slot <= write_slot_next;
        run_min    <= run_min_next;
        run_max    <= run_max_next;
        newest_in  <= newest_in_next;
        newest_out <= newest_out_next;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Status after the request travels beside the ring read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit        <= hit_next;
      s1_count      <= COUNT_W'(held_count_next);
      s1_min        <= run_min_next;
      s1_max        <= run_max_next;
      s1_latest_in  <= newest_in_next;
      s1_latest_out <= newest_out_next;
    end
    if (advance && s1_valid) begin
      out_hit  <= s1_hit;
      out_data <= {1'b0,
                   s1_hit ? rd_pair.outside_temp : SENTINEL,
                   s1_hit ? rd_pair.inside_temp  : SENTINEL,
                   s1_latest_out, s1_latest_in, s1_max, s1_min, s1_count};
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_hit;

endmodule

// ===== sv/sph_checker.sv =====
// Port-level checks for the sample pair history block, bound to the top level.
module sph_checker (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [103:0]  m_axis_tdata,
  input logic [0:0]    m_axis_tuser
);
  import sph_pkg::*;

  logic signed [TEMP_W-1:0] min_f;
  logic signed [TEMP_W-1:0] max_f;

  assign min_f = m_axis_tdata[22:7];
  assign max_f = m_axis_tdata[38:23];

  // A result without a hit carries the sentinel in both read fields.
  a_miss_sentinel: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[86:71] == SENTINEL) && (m_axis_tdata[102:87] == SENTINEL))
    else $error("read fields not sentinel on a miss");

  // An empty history reports the sentinel for min, max and the newest pair.
  a_empty_sentinel: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[6:0] == '0)) |->
      (min_f == SENTINEL) && (max_f == SENTINEL) &&
      (m_axis_tdata[54:39] == SENTINEL) && (m_axis_tdata[70:55] == SENTINEL))
    else $error("empty history without sentinel status");

  // Running min never exceeds running max and never falls below the floor.
  a_min_max_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (min_f <= max_f) && (min_f >= SENTINEL))
    else $error("running min and max out of order");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // With no result waiting at the output, a new request is always taken.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while the output is empty");

endmodule

bind sample_pair_history_min_max sph_checker u_sph_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== sim/sph_history_check_pkg.sv =====
// Scoreboard class that predicts and checks the sample pair history results.
package sph_history_check_pkg;
  import sph_pkg::*;

  typedef struct {
    logic [COUNT_W-1:0]       count;
    logic signed [TEMP_W-1:0] min_t;
    logic signed [TEMP_W-1:0] max_t;
    logic signed [TEMP_W-1:0] last_in;
    logic signed [TEMP_W-1:0] last_out;
    logic signed [TEMP_W-1:0] rd_in;
    logic signed [TEMP_W-1:0] rd_out;
    logic                     hit;
  } history_status_t;

  class pair_history_scoreboard;
    logic signed [TEMP_W-1:0] inside_ring [DEPTH_DEF];
    logic signed [TEMP_W-1:0] outside_ring [DEPTH_DEF];
    int unsigned              held_count;
    int unsigned              next_slot;
    logic signed [TEMP_W-1:0] low_mark;
    logic signed [TEMP_W-1:0] high_mark;
    logic signed [TEMP_W-1:0] newest_in;
    logic signed [TEMP_W-1:0] newest_out;
    history_status_t          status_q[$];
    int                       failures;

    function new();
      empty_history();
      failures = 0;
    endfunction

    function void empty_history();
      held_count = 0;
      next_slot  = 0;
      low_mark   = SENTINEL;
      high_mark  = SENTINEL;
      newest_in  = SENTINEL;
      newest_out = SENTINEL;
    endfunction

    // Anything below -300 degrees is pinned to the sentinel.
    function logic signed [TEMP_W-1:0] clamp_temp(logic signed [TEMP_W-1:0] v);
      return (v < SENTINEL) ? SENTINEL : v;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_request(kind_t kind, logic signed [TEMP_W-1:0] tin,
                               logic signed [TEMP_W-1:0] tout,
                               logic [INDEX_W-1:0] idx);
      history_status_t          st;
      logic signed [TEMP_W-1:0] a;
      logic signed [TEMP_W-1:0] b;
      logic signed [TEMP_W-1:0] lo;
      logic signed [TEMP_W-1:0] hi;
      int unsigned              pos;
      st.rd_in  = SENTINEL;
      st.rd_out = SENTINEL;
      st.hit    = 1'b0;
      case (kind)
        KIND_ADD: begin
          a  = clamp_temp(tin);
          b  = clamp_temp(tout);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          inside_ring[next_slot]  = a;
          outside_ring[next_slot] = b;
          next_slot = (next_slot + 1) % DEPTH_DEF;
          if (held_count < DEPTH_DEF) held_count++;
          newest_in  = a;
          newest_out = b;
          if (held_count == 1) begin
            low_mark  = lo;
            high_mark = hi;
          end else begin
            if (lo < low_mark) low_mark = lo;
            if (hi > high_mark) high_mark = hi;
          end
        end
        KIND_READ: begin
          if (idx < held_count) begin
            pos = (next_slot + DEPTH_DEF - held_count + idx) % DEPTH_DEF;
            st.rd_in  = inside_ring[pos];
            st.rd_out = outside_ring[pos];
            st.hit    = 1'b1;
          end
        end
        KIND_CLEAR: empty_history();
        default: ;
      endcase
      st.count    = COUNT_W'(held_count);
      st.min_t    = low_mark;
      st.max_t    = high_mark;
      st.last_in  = newest_in;
      st.last_out = newest_out;
      status_q.push_back(st);
    endfunction

    function void check_field(string name, logic [TEMP_W-1:0] want,
                              logic [TEMP_W-1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [103:0] data, logic [0:0] flags);
      history_status_t st;
      if (status_q.size() == 0) begin
        failures++;
        $display("%0t: result with nothing pending, expected none, actual 0x%h/%b",
                 $time, data, flags);
        return;
      end
      st = status_q.pop_front();
      check_field("reading_count", TEMP_W'(st.count), TEMP_W'(data[6:0]));
      check_field("min_temp", st.min_t, data[22:7]);
      check_field("max_temp", st.max_t, data[38:23]);
      check_field("latest_inside", st.last_in, data[54:39]);
      check_field("latest_outside", st.last_out, data[70:55]);
      check_field("read_inside", st.rd_in, data[86:71]);
      check_field("read_outside", st.rd_out, data[102:87]);
      check_field("read_hit", TEMP_W'(st.hit), TEMP_W'(flags[0]));
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// Testbench top for the sample pair history with running min and max.
module tb_top;
  import sph_pkg::*;
  import sph_history_check_pkg::*;

  localparam int RANDOM_ITEMS = 1750;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  bit           idle_on = 1'b1;

  pair_history_scoreboard sb = new();

  sample_pair_history_min_max u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Results are checked before the request of the same edge is noted; a result
  // always trails its request through the ring read register and the output register.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(kind_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16],
                        s_axis_tdata[37:32]);
    end
  end

  task automatic send_request(kind_t kind, logic signed [TEMP_W-1:0] tin,
                              logic signed [TEMP_W-1:0] tout, logic [INDEX_W-1:0] idx);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, idx, tout, tin};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // The extra edge lets the monitor note the last accepted request first.
  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [TEMP_W-1:0] pick_temp();
    case ($urandom_range(0, 7))
      0:       return TEMP_W'($urandom);
      1:       return TEMP_W'(-19203 + int'($urandom_range(0, 6)));
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return TEMP_W'(int'($urandom_range(0, 51967)) - 19200);
    endcase
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if (sb.held_count != 0 && $urandom_range(0, 4) != 0)
      return INDEX_W'($urandom_range(0, sb.held_count - 1));
    return INDEX_W'($urandom);
  endfunction

  // Receiver: ready for random stretches, stalled in bursts while idling is on.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned pick;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_NONE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty history, saturation, extremes, past-count reads, clear.
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd0);
    send_request(KIND_NONE, 16'sh7fff, 16'sh8000, 6'd63);
    send_request(KIND_ADD, 16'sh8000, 16'sh7fff, 6'd0);
    send_request(KIND_ADD, -16'sd19201, -16'sd19200, 6'd63);
    send_request(KIND_ADD, 16'sd0, -16'sd1, 6'd0);
    send_request(KIND_ADD, 16'sh7fff, 16'sh7fff, 6'd0);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd0);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd3);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd4);
    send_request(KIND_READ, 16'shffff, 16'shffff, 6'd63);
    send_request(KIND_NONE, 16'sd5, 16'sd5, 6'd1);
    send_request(KIND_CLEAR, 16'sd0, 16'sd0, 6'd0);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd0);
    send_request(KIND_ADD, -16'sd19200, -16'sd19200, 6'd0);
    send_request(KIND_ADD, 16'sd100, -16'sd200, 6'd0);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd1);
    send_request(KIND_ADD, 16'sh5555, 16'shaaaa, 6'h2a);
    send_request(KIND_ADD, 16'shaaaa, 16'sh5555, 6'h15);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd3);
    send_request(KIND_CLEAR, 16'sd1, 16'sd1, 6'd5);
    send_request(KIND_ADD, 16'sd12345, 16'sd12344, 6'd0);
    send_request(KIND_READ, 16'sd0, 16'sd0, 6'd0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // Random: runs of adds and reads between clears, long enough to wrap the ring.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(10, 250);
      for (int unsigned i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
        if (sent == RANDOM_ITEMS / 2) begin
          s_axis_tvalid <= 1'b0;
          wait_drained();
        end
        if (sent > RANDOM_ITEMS * 85 / 100) idle_on = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_request(KIND_ADD, pick_temp(), pick_temp(), INDEX_W'($urandom));
        else if (pick < 94)
          send_request(KIND_READ, TEMP_W'($urandom), TEMP_W'($urandom), pick_index());
        else if (pick < 99)
          send_request(KIND_NONE, TEMP_W'($urandom), TEMP_W'($urandom), INDEX_W'($urandom));
        else
          send_request(KIND_CLEAR, TEMP_W'($urandom), TEMP_W'($urandom), INDEX_W'($urandom));
        sent++;
      end
      if (sent < RANDOM_ITEMS) begin
        send_request(KIND_CLEAR, TEMP_W'($urandom), TEMP_W'($urandom), INDEX_W'($urandom));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sample_pair_history_min_max.f =====
sv/sph_pkg.sv
sv/sph_ring.sv
sv/sample_pair_history_min_max.sv
sv/sph_checker.sv
sim/sph_history_check_pkg.sv
sim/tb_top.sv
